[rtl/mfbr_pkg.sv]
`default_nettype none

package mfbr_pkg;

    // Reservoir and request limits.
    localparam int BUF_BYTES = 8;
    localparam int MAX_POP   = 32;

    // Field widths fixed by the interface.
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 6;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int LEFT_W  = 7;

    // Widths that follow from the reservoir size.
    localparam int RES_W   = BUF_BYTES * 8;
    localparam int IDX_W   = $clog2(BUF_BYTES);
    localparam int HELD_W  = $clog2(BUF_BYTES + 1);
    localparam int BITS_W  = $clog2(RES_W + 1);
    localparam int BBITS_W = COUNT_W + 3;
    localparam int CMP_W   = (BITS_W > BBITS_W) ? BITS_W : BBITS_W;

    // Depth of the queue between the front and back ends.
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD      = 2'd0;
    localparam logic [OP_W-1:0] OP_POP       = 2'd1;
    localparam logic [OP_W-1:0] OP_SKIP_BITS = 2'd2;
    localparam logic [OP_W-1:0] OP_SKIP_BYTES = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // A classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] count;
        logic               too_wide;
        logic [BBITS_W-1:0] byte_bits;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/mfbr_front.sv]
`default_nettype none

module mfbr_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [mfbr_pkg::OP_W-1:0]    in_op,
    input  wire logic [mfbr_pkg::BYTE_W-1:0]  in_data_byte,
    input  wire logic [mfbr_pkg::COUNT_W-1:0] in_count,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output mfbr_pkg::cmd_t                   cmd
);
    import mfbr_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic take;

    // The stage is free when empty or when its word moves on this cycle.
    assign in_ready = !valid_reg || cmd_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        cmd_next.op        = in_op;
        cmd_next.data_byte = in_data_byte;
        cmd_next.count     = in_count;
        cmd_next.too_wide  = (COUNT_W'(in_count) > COUNT_W'(MAX_POP));
        cmd_next.byte_bits = {in_count, 3'b000};
    end

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

[rtl/mfbr_queue.sv]
`default_nettype none

module mfbr_queue
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire mfbr_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  wire logic     out_ready,
    output mfbr_pkg::cmd_t out_cmd
);
    import mfbr_pkg::*;

    cmd_t mem [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready  = (cnt_reg != QCNT_W'(Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/mfbr_back.sv]
`default_nettype none

module mfbr_back
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire mfbr_pkg::cmd_t             cmd,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [mfbr_pkg::VALUE_W-1:0]    out_value,
    output logic [mfbr_pkg::STAT_W-1:0]     out_status,
    output logic [mfbr_pkg::LEFT_W-1:0]     out_bits_left
);
    import mfbr_pkg::*;

    logic [BYTE_W-1:0] res_reg [BUF_BYTES];
    logic [BYTE_W-1:0] shifted [BUF_BYTES];
    logic [HELD_W-1:0] held_reg, held_next;
    logic [2:0]        off_reg, off_next;
    logic              out_valid_reg;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [LEFT_W-1:0]  left_reg, left_next;

    logic              exec;
    logic [RES_W-1:0]  res_flat;
    logic [RES_W-1:0]  window;
    logic [VALUE_W-1:0] pop_val;
    logic [CMP_W-1:0]  held_bits;
    logic [BITS_W-1:0] total;
    logic [BITS_W-1:0] bits_after;
    logic [HELD_W-1:0] drop;
    logic              shift_en;
    logic              load_en;
    logic              bit_short;
    logic              byte_short;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign exec      = cmd_valid && cmd_ready;

    // Front byte sits in the top bits so the bit offset is a left shift.
    always_comb
    begin
        for (int i = 0; i < BUF_BYTES; i++)
        begin
            res_flat[RES_W-1-8*i -: 8] = res_reg[i];
        end
    end

    assign window    = res_flat << off_reg;
    assign pop_val   = window[RES_W-1 -: VALUE_W] >> (COUNT_W'(VALUE_W) - cmd.count);
    assign held_bits = CMP_W'({held_reg, 3'b000}) - CMP_W'(off_reg);
    assign total     = BITS_W'(off_reg) + BITS_W'(cmd.count);
    assign bit_short  = (CMP_W'(cmd.count) > held_bits);
    assign byte_short = (CMP_W'(cmd.byte_bits) > held_bits);

    always_comb
    begin
        held_next   = held_reg;
        off_next    = off_reg;
        drop        = '0;
        shift_en    = 1'b0;
        load_en     = 1'b0;
        value_next  = '0;
        status_next = ST_OK;
        case (cmd.op)
            OP_LOAD:
            begin
                if (held_reg >= HELD_W'(BUF_BYTES))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    load_en   = 1'b1;
                    held_next = held_reg + 1'b1;
                end
            end
            OP_POP, OP_SKIP_BITS:
            begin
                if (bit_short || (cmd.op == OP_POP && cmd.too_wide))
                begin
                    status_next = ST_SHORT;
                end
                else
                begin
                    // Bytes wholly consumed leave the front; the rest of the
                    // total becomes the new offset.
                    drop      = HELD_W'(total >> 3);
                    shift_en  = 1'b1;
                    held_next = held_reg - drop;
                    off_next  = total[2:0];
                    if (cmd.op == OP_POP)
                    begin
                        value_next = pop_val;
                    end
                end
            end
            OP_SKIP_BYTES:
            begin
                if (byte_short)
                begin
                    status_next = ST_SHORT;
                end
                else
                begin
                    drop      = HELD_W'(cmd.count);
                    shift_en  = 1'b1;
                    held_next = held_reg - drop;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        logic [HELD_W:0] src;
        for (int i = 0; i < BUF_BYTES; i++)
        begin
            src = (HELD_W + 1)'(i) + {1'b0, drop};
            if (src < (HELD_W + 1)'(BUF_BYTES))
            begin
                shifted[i] = res_reg[src[IDX_W-1:0]];
            end
            else
            begin
                shifted[i] = res_reg[i];
            end
        end
    end

    assign bits_after = BITS_W'({held_next, 3'b000}) - BITS_W'(off_next);
    assign left_next  = LEFT_W'(bits_after);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                held_reg <= held_next;
                off_reg  <= off_next;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            left_reg   <= left_next;
            if (load_en)
            begin
                res_reg[held_reg[IDX_W-1:0]] <= cmd.data_byte;
            end
            else if (shift_en)
            begin
                res_reg <= shifted;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = value_reg;
    assign out_status    = status_reg;
    assign out_bits_left = left_reg;

endmodule

`default_nettype wire

[rtl/msb_first_bit_reader_core.sv]
// Throughput: one request word per cycle while the result side is not stalled,
// limited by the combinational barrel shifter and reservoir update in the back
// end, whatever the mix of operations.
// Reset (rst_n low, asynchronous) empties the reservoir, clears the bit offset,
// the queue and both output stages; reservoir bytes themselves are not cleared.
`default_nettype none

module msb_first_bit_reader_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] data_byte, [13:8] count, rest zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] value, [38:32] bits_left, rest zero
    output logic [1:0]       m_axis_tuser    // [1:0] status
);
    import mfbr_pkg::*;

    // The front end registers and classifies each request word, the queue
    // lets the two halves stall independently, and the back end owns the
    // reservoir and drives the result register.
    logic f_valid;
    logic f_ready;
    cmd_t f_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    logic [VALUE_W-1:0] value;
    logic [STAT_W-1:0]  status;
    logic [LEFT_W-1:0]  bits_left;

    mfbr_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_op        (s_axis_tuser),
        .in_data_byte (s_axis_tdata[7:0]),
        .in_count     (s_axis_tdata[13:8]),
        .cmd_valid    (f_valid),
        .cmd_ready    (f_ready),
        .cmd          (f_cmd)
    );

    mfbr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    mfbr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_valid),
        .cmd_ready     (q_ready),
        .cmd           (q_cmd),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_value     (value),
        .out_status    (status),
        .out_bits_left (bits_left)
    );

    // Result word packing: value in the low bits, the bits still held above it.
    assign m_axis_tdata = {1'b0, bits_left, value};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire

[test/msb_first_bit_reader_core_test.sv]
`timescale 1ns / 1ps

module msb_first_bit_reader_core_test;

    import mfbr_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] count;
    } bit_request_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STAT_W-1:0]  status;
        logic [LEFT_W-1:0]  bits_left;
    } read_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] data_byte, [13:8] count, rest zero
    logic [1:0]  s_axis_tuser = '0;   // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] value, [38:32] bits_left, rest zero
    logic [1:0]  m_axis_tuser;        // [1:0] status

    msb_first_bit_reader_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bit_request_t pending_requests[$];
    read_result_t awaited_results[$];
    int unsigned  failures = 0;
    int unsigned  words_sent = 0;
    int unsigned  results_seen = 0;

    // Shadow of the reservoir: front byte at index 0.
    logic [7:0]  shadow_bytes[BUF_BYTES];
    int unsigned shadow_held = 0;
    int unsigned shadow_offset = 0;

    initial
    begin
        foreach (shadow_bytes[i])
            shadow_bytes[i] = '0;
    end

    function automatic void drop_front_bytes(int unsigned n);
        if (n >= shadow_held)
        begin
            shadow_held = 0;
        end
        else
        begin
            for (int unsigned i = 0; i < shadow_held - n; i++)
                shadow_bytes[i] = shadow_bytes[i + n];
            shadow_held = shadow_held - n;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] extract_bits(int unsigned n);
        logic [RES_W-1:0]   window;
        logic [VALUE_W-1:0] bits;
        int unsigned        total;
        for (int i = 0; i < BUF_BYTES; i++)
            window[RES_W-1-8*i -: 8] = shadow_bytes[i];
        window = window << shadow_offset;
        bits = (n == 0) ? '0 : (window[RES_W-1 -: VALUE_W] >> (VALUE_W - n));
        total = shadow_offset + n;
        drop_front_bytes(total / 8);
        shadow_offset = total % 8;
        return bits;
    endfunction

    function automatic read_result_t advance_reader(bit_request_t req);
        read_result_t res;
        int unsigned  avail;
        int unsigned  n;
        res = '0;
        res.status = ST_OK;
        avail = shadow_held * 8 - shadow_offset;
        n = req.count;
        case (req.op)
            OP_LOAD:
            begin
                if (shadow_held >= BUF_BYTES)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    shadow_bytes[shadow_held] = req.data_byte;
                    shadow_held++;
                end
            end
            OP_POP:
            begin
                if (n > MAX_POP || n > avail)
                    res.status = ST_SHORT;
                else
                    res.value = extract_bits(n);
            end
            OP_SKIP_BITS:
            begin
                if (n > avail)
                    res.status = ST_SHORT;
                else
                    void'(extract_bits(n));
            end
            default:
            begin
                if (n * 8 > avail)
                    res.status = ST_SHORT;
                else
                    drop_front_bytes(n);
            end
        endcase
        res.bits_left = LEFT_W'(shadow_held * 8 - shadow_offset);
        return res;
    endfunction

    // Sender: holds each word until it is taken, and idles now and then except in a quiet stretch.
    bit_request_t offered;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                awaited_results.push_back(advance_reader(offered));
                words_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_requests.size() > 0 &&
                    ((words_sent >= 900 && words_sent < 1200) || $urandom_range(99) >= 10))
                begin
                    offered = pending_requests.pop_front();
                    s_axis_tdata  <= {2'b00, offered.count, offered.data_byte};
                    s_axis_tuser  <= offered.op;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word, with one long hold-off to back the block up.
    int unsigned  hold_left = 0;
    bit           hold_done = 1'b0;
    read_result_t got;
    read_result_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value     = m_axis_tdata[31:0];
                got.bits_left = m_axis_tdata[38:32];
                got.status    = m_axis_tuser;
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    $error("result word with nothing awaited: value %0h status %0d bits_left %0d",
                           got.value, got.status, got.bits_left);
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("value mismatch: expected %0h, actual %0h", want.value, got.value);
                        failures++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        failures++;
                    end
                    if (got.bits_left !== want.bits_left)
                    begin
                        $error("bits_left mismatch: expected %0d, actual %0d",
                               want.bits_left, got.bits_left);
                        failures++;
                    end
                end
            end
            if (!hold_done && results_seen >= 600)
            begin
                hold_done = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= (results_seen >= 900 && results_seen < 1200) ||
                                 ($urandom_range(99) >= 10);
            end
        end
    end

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [7:0] data_byte,
                                 input logic [5:0] count);
        bit_request_t req;
        req.op        = op;
        req.data_byte = data_byte;
        req.count     = count;
        pending_requests.push_back(req);
    endtask

    task automatic wait_for_drain();
        while (pending_requests.size() > 0 || s_axis_tvalid || awaited_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned queued;
        int unsigned budget;
        int unsigned loads;
        int unsigned n;
        int unsigned pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty reservoir, full reservoir, wide pops, and the partly
        // consumed last byte that a byte skip must not drop.
        queue_request(OP_POP, 8'h00, 6'd0);
        queue_request(OP_POP, 8'h00, 6'd1);
        queue_request(OP_SKIP_BITS, 8'hFF, 6'd1);
        queue_request(OP_SKIP_BYTES, 8'h00, 6'd0);
        queue_request(OP_SKIP_BYTES, 8'h00, 6'd1);
        queue_request(OP_LOAD, 8'h00, 6'd63);
        queue_request(OP_LOAD, 8'hFF, 6'd0);
        queue_request(OP_LOAD, 8'hA5, 6'd0);
        queue_request(OP_LOAD, 8'h5A, 6'd0);
        queue_request(OP_LOAD, 8'h3C, 6'd0);
        queue_request(OP_LOAD, 8'hC3, 6'd0);
        queue_request(OP_LOAD, 8'h81, 6'd0);
        queue_request(OP_LOAD, 8'h7E, 6'd0);
        queue_request(OP_LOAD, 8'h12, 6'd0);
        queue_request(OP_POP, 8'h00, 6'd33);
        queue_request(OP_POP, 8'hFF, 6'd63);
        queue_request(OP_SKIP_BYTES, 8'h00, 6'd63);
        queue_request(OP_POP, 8'h00, 6'd32);
        queue_request(OP_POP, 8'h00, 6'd3);
        queue_request(OP_SKIP_BYTES, 8'h00, 6'd1);
        queue_request(OP_SKIP_BITS, 8'h00, 6'd5);
        queue_request(OP_POP, 8'h00, 6'd12);
        queue_request(OP_SKIP_BYTES, 8'h00, 6'd1);
        queue_request(OP_SKIP_BITS, 8'h00, 6'd5);
        queue_request(OP_POP, 8'h00, 6'd4);
        wait_for_drain();

        // Random part in three phases, the sender pausing for a full drain between them.
        for (int phase = 0; phase < 3; phase++)
        begin
            queued = 0;
            while (queued < 600)
            begin
                if ($urandom_range(3) != 0)
                begin
                    // A fill followed by reads that stay within what was loaded.
                    loads = $urandom_range(1, BUF_BYTES);
                    for (int i = 0; i < loads; i++)
                        queue_request(OP_LOAD, 8'($urandom_range(255)), 6'($urandom_range(63)));
                    queued += loads;
                    budget = loads * 8;
                    while (budget > 0)
                    begin
                        pick = $urandom_range(9);
                        if (pick < 6)
                        begin
                            n = $urandom_range(0, (budget < MAX_POP) ? budget : MAX_POP);
                            queue_request(OP_POP, 8'($urandom_range(255)), 6'(n));
                            budget -= n;
                        end
                        else if (pick < 8)
                        begin
                            n = $urandom_range(0, (budget < 20) ? budget : 20);
                            queue_request(OP_SKIP_BITS, 8'($urandom_range(255)), 6'(n));
                            budget -= n;
                        end
                        else
                        begin
                            n = $urandom_range(0, budget / 8);
                            queue_request(OP_SKIP_BYTES, 8'($urandom_range(255)), 6'(n));
                            budget -= n * 8;
                            if (n == 0)
                                budget = (budget > 8) ? budget - 8 : 0;
                        end
                        queued++;
                    end
                end
                else
                begin
                    // Noise: any operation with any count.
                    for (int i = 0; i < 12; i++)
                        queue_request(OP_W'($urandom_range(3)), 8'($urandom_range(255)),
                                      6'($urandom_range(63)));
                    queued += 12;
                end
            end
            wait_for_drain();
        end

        repeat (20) @(posedge clk);
        if (failures == 0 && awaited_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/mfbr_pkg.sv
rtl/mfbr_front.sv
rtl/mfbr_queue.sv
rtl/mfbr_back.sv
rtl/msb_first_bit_reader_core.sv
test/msb_first_bit_reader_core_test.sv
